// File: rtl/cnzr_pkg.sv
`timescale 1ns / 1ps

package cnzr_pkg;

  localparam int MAX_RANK_DEF = 4;
  localparam int OUT_BINS_DEF = 64;
  localparam int OUT_BINS_MAX = 64;

  localparam int EXT_REGS   = 4;
  localparam int EXT_W      = 11;
  localparam int COORD_W    = 10;
  localparam int MASK_W     = 4;
  localparam int COUNT_W    = 24;
  localparam int BIN_OUT_W  = 6;
  localparam int ELEM_W     = 32;
  localparam int EXTENT_MAX = 1024;

  // Internal bin values run 0..OUT_BINS, where OUT_BINS marks "out of range".
  localparam int BIN_W = $clog2(OUT_BINS_MAX + 1);

  localparam int OUT_DATA_W = ((BIN_OUT_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - BIN_OUT_W - COUNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_AXIS3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MASK  = 3'd4;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } cnzr_state_t;

  typedef logic [EXT_REGS-1:0][EXT_W-1:0] cnzr_ext_t;

  // One element leaving the index pipeline toward the counter memory.
  typedef struct packed {
    logic             valid;
    logic             inc;
    logic             last_el;
    logic [BIN_W-1:0] bin;
    logic [BIN_W-1:0] nbins;
  } cnzr_item_t;

endpackage

// File: rtl/axis_count_nonzero_reduce_top.sv
`timescale 1ns / 1ps

// Count-nonzero reduction over a streamed rank-MAX_RANK tensor.
// Input stream: one float32 element per word on in_tdata, row-major order,
// in_tlast on the final element of the tensor. A word is nonzero when bits
// 30..0 are not all zero. Elements are taken one per cycle while counting.
// Output stream: after the final element, one word per bin in bin order,
// bin index and saturating 24-bit count in out_tdata, out_tlast on the last.
// After the final element is taken it passes the index stages and the counter
// update, then the sweep reads each bin into the output register; a bin is read
// only when no read is pending and the output register is free or being taken.
// The sweep visits all OUT_BINS entries, zeroing each, and in_tready stays low
// from a final element until the sweep ends.
// Reset: extents return to 1 and the mask to 0; a clearing pass zeroes the
// counter memory, with in_tready low meanwhile.
// A stalled receiver holds the current bin word and pauses the sweep.
// Configuration writes land at once and must be made while no element is
// in flight.
module axis_count_nonzero_reduce_top #(
  parameter int MAX_RANK = cnzr_pkg::MAX_RANK_DEF,
  parameter int OUT_BINS = cnzr_pkg::OUT_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cnzr_pkg::ELEM_W-1:0]        in_tdata,   // [31:0] element_bits
  input  logic                               in_tlast,   // final_element
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cnzr_pkg::OUT_DATA_W-1:0]    out_tdata,  // [5:0] bin_index, [29:6] nonzero_count
  output logic                               out_tlast,  // last_bin
  input  logic                               cfg_we,
  input  logic [cnzr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cnzr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EXT_REGS = cnzr_pkg::EXT_REGS;
  localparam int EXT_W    = cnzr_pkg::EXT_W;
  localparam int MASK_W   = cnzr_pkg::MASK_W;
  localparam int USED     = (MAX_RANK < EXT_REGS) ? MAX_RANK : EXT_REGS;
  localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << USED) - 1);

  cnzr_pkg::cnzr_ext_t        ext_r;
  cnzr_pkg::cnzr_ext_t        ext_eff;
  logic [MASK_W-1:0]          mask_r;
  logic                       reduce_all;
  logic [MASK_W-1:0]          keep;
  logic                       accept;
  cnzr_pkg::cnzr_item_t       item;
  logic [cnzr_pkg::BIN_OUT_W-1:0] out_bin;
  logic [cnzr_pkg::COUNT_W-1:0]   out_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < EXT_REGS; k++) begin
        ext_r[k] <= EXT_W'(1);
      end
      mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cnzr_pkg::REG_EXTENT_AXIS0: ext_r[0] <= cfg_data;
        cnzr_pkg::REG_EXTENT_AXIS1: ext_r[1] <= cfg_data;
        cnzr_pkg::REG_EXTENT_AXIS2: ext_r[2] <= cfg_data;
        cnzr_pkg::REG_EXTENT_AXIS3: ext_r[3] <= cfg_data;
        cnzr_pkg::REG_REDUCE_MASK:  mask_r   <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // An extent of zero acts as one; anything above the maximum is clipped.
  always_comb begin
    for (int k = 0; k < EXT_REGS; k++) begin
      if (ext_r[k] == '0) begin
        ext_eff[k] = EXT_W'(1);
      end else if (ext_r[k] > EXT_W'(cnzr_pkg::EXTENT_MAX)) begin
        ext_eff[k] = EXT_W'(cnzr_pkg::EXTENT_MAX);
      end else begin
        ext_eff[k] = ext_r[k];
      end
    end
  end

  assign reduce_all = (mask_r == '0) || ((mask_r & FULL_MASK) == FULL_MASK);
  assign keep       = reduce_all ? '0 : ~mask_r;
  assign accept     = in_tvalid && in_tready;

  cnzr_index #(
    .MAX_RANK (MAX_RANK),
    .OUT_BINS (OUT_BINS)
  ) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .nonzero_i (|in_tdata[cnzr_pkg::ELEM_W-2:0]),
    .last_i    (in_tlast),
    .ext_i     (ext_eff),
    .keep_i    (keep),
    .item_o    (item)
  );

  cnzr_count #(
    .OUT_BINS (OUT_BINS)
  ) u_count (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (item),
    .take_last_i  (accept && in_tlast),
    .ready_o      (in_tready),
    .out_tready_i (out_tready),
    .out_valid_o  (out_tvalid),
    .out_bin_o    (out_bin),
    .out_count_o  (out_count),
    .out_last_o   (out_tlast)
  );

  assign out_tdata = {{cnzr_pkg::OUT_PAD_W{1'b0}}, out_count, out_bin};

endmodule

// File: rtl/cnzr_index.sv
`timescale 1ns / 1ps

module cnzr_index #(
  parameter int MAX_RANK = cnzr_pkg::MAX_RANK_DEF,
  parameter int OUT_BINS = cnzr_pkg::OUT_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept_i,
  input  logic                               nonzero_i,
  input  logic                               last_i,
  input  cnzr_pkg::cnzr_ext_t                ext_i,
  input  logic [cnzr_pkg::MASK_W-1:0]        keep_i,
  output cnzr_pkg::cnzr_item_t               item_o
);

  localparam int BIN_W   = cnzr_pkg::BIN_W;
  localparam int EXT_W   = cnzr_pkg::EXT_W;
  localparam int COORD_W = cnzr_pkg::COORD_W;
  localparam int SUM_W   = BIN_W + EXT_W + 1;
  localparam int STAGES  = MAX_RANK + 1;

  logic [EXT_W-1:0]   axis_ext  [MAX_RANK];
  logic               axis_keep [MAX_RANK];
  logic [COORD_W-1:0] coord_r   [MAX_RANK];
  logic [COORD_W-1:0] coord_nxt [MAX_RANK];
  logic [MAX_RANK:0]  carry;
  logic [MAX_RANK-1:0] wrap;

  logic               st_valid_r [STAGES];
  logic               st_nz_r    [STAGES];
  logic               st_last_r  [STAGES];
  logic [BIN_W-1:0]   st_idx_r   [STAGES];
  logic [BIN_W-1:0]   st_nb_r    [STAGES];
  logic [COORD_W-1:0] st_coord_r [STAGES][MAX_RANK];

  // Axes beyond the extent registers have size one and are never kept.
  for (genvar k = 0; k < MAX_RANK; k++) begin : g_axis
    if (k < cnzr_pkg::EXT_REGS) begin : g_reg
      assign axis_ext[k]  = ext_i[k];
      assign axis_keep[k] = keep_i[k];
    end else begin : g_unit
      assign axis_ext[k]  = EXT_W'(1);
      assign axis_keep[k] = 1'b0;
    end
  end

  // Odometer step, innermost axis first.
  always_comb begin
    carry[MAX_RANK] = 1'b1;
    for (int k = MAX_RANK - 1; k >= 0; k--) begin
      wrap[k]      = ({1'b0, coord_r[k]} + EXT_W'(1)) >= axis_ext[k];
      carry[k]     = carry[k+1] & wrap[k];
      coord_nxt[k] = coord_r[k];
      if (carry[k+1]) begin
        coord_nxt[k] = wrap[k] ? '0 : coord_r[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        coord_r[k] <= '0;
      end
    end else if (accept_i) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        coord_r[k] <= last_i ? '0 : coord_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r[0] <= 1'b0;
    end else begin
      st_valid_r[0] <= accept_i;
    end
  end

  always_ff @(posedge clk) begin
    st_nz_r[0]    <= nonzero_i;
    st_last_r[0]  <= last_i;
    st_idx_r[0]   <= '0;
    st_nb_r[0]    <= BIN_W'(1);
    st_coord_r[0] <= coord_r;
  end

  // One stage per axis: on a kept axis, bin = bin * extent + coord and bin count =
  // count * extent, both held at OUT_BINS once they reach it; other axes pass both on.
  for (genvar s = 0; s < MAX_RANK; s++) begin : g_stage
    logic [SUM_W-1:0] idx_sum;
    logic [SUM_W-1:0] nb_prod;
    logic [BIN_W-1:0] idx_sat;
    logic [BIN_W-1:0] nb_sat;

    assign idx_sum = SUM_W'(st_idx_r[s]) * SUM_W'(axis_ext[s]) + SUM_W'(st_coord_r[s][s]);
    assign nb_prod = SUM_W'(st_nb_r[s]) * SUM_W'(axis_ext[s]);
    assign idx_sat = (idx_sum >= SUM_W'(OUT_BINS)) ? BIN_W'(OUT_BINS) : idx_sum[BIN_W-1:0];
    assign nb_sat  = (nb_prod > SUM_W'(OUT_BINS)) ? BIN_W'(OUT_BINS) : nb_prod[BIN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[s+1] <= 1'b0;
      end else begin
        st_valid_r[s+1] <= st_valid_r[s];
      end
    end

    always_ff @(posedge clk) begin
      st_nz_r[s+1]    <= st_nz_r[s];
      st_last_r[s+1]  <= st_last_r[s];
      st_coord_r[s+1] <= st_coord_r[s];
      st_idx_r[s+1]   <= axis_keep[s] ? idx_sat : st_idx_r[s];
      st_nb_r[s+1]    <= axis_keep[s] ? nb_sat : st_nb_r[s];
    end
  end

  always_comb begin
    item_o.valid   = st_valid_r[MAX_RANK];
    item_o.inc     = st_nz_r[MAX_RANK] && (st_idx_r[MAX_RANK] < BIN_W'(OUT_BINS));
    item_o.last_el = st_last_r[MAX_RANK];
    item_o.bin     = st_idx_r[MAX_RANK];
    item_o.nbins   = st_nb_r[MAX_RANK];
  end

endmodule

// File: rtl/cnzr_count.sv
`timescale 1ns / 1ps

module cnzr_count #(
  parameter int OUT_BINS = cnzr_pkg::OUT_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cnzr_pkg::cnzr_item_t              item_i,
  input  logic                              take_last_i,
  output logic                              ready_o,
  input  logic                              out_tready_i,
  output logic                              out_valid_o,
  output logic [cnzr_pkg::BIN_OUT_W-1:0]    out_bin_o,
  output logic [cnzr_pkg::COUNT_W-1:0]      out_count_o,
  output logic                              out_last_o
);

  localparam int AW      = (OUT_BINS > 1) ? $clog2(OUT_BINS) : 1;
  localparam int BIN_W   = cnzr_pkg::BIN_W;
  localparam int COUNT_W = cnzr_pkg::COUNT_W;

  logic [COUNT_W-1:0] mem [OUT_BINS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [COUNT_W-1:0] rdata_r;

  cnzr_pkg::cnzr_state_t state_r, state_nxt;
  cnzr_pkg::cnzr_item_t  wb_r;
  logic [AW-1:0]         ptr_r;
  logic [BIN_W-1:0]      nb_r;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_W-1:0]    fwd_data_r;

  logic                  rd_pend_r;
  logic [AW-1:0]         rd_bin_r;
  logic                  rd_last_r;

  logic                  out_valid_r;
  logic [cnzr_pkg::BIN_OUT_W-1:0] out_bin_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_last_r;

  logic [COUNT_W-1:0]    wb_cur;
  logic [COUNT_W-1:0]    wb_new;
  logic                  issue_ok;
  logic                  in_range;
  logic                  emit_act;
  logic                  emit_read;
  logic                  emit_done;
  logic                  drain_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // A write at the same edge as this word's read is not seen by the read.
  assign wb_cur = (fwd_valid_r && fwd_addr_r == wb_r.bin[AW-1:0]) ? fwd_data_r : rdata_r;
  assign wb_new = (&wb_cur) ? wb_cur : wb_cur + 1'b1;

  assign drain_done = wb_r.valid && wb_r.last_el;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cnzr_pkg::ST_RUN: begin
        if (take_last_i) begin
          state_nxt = cnzr_pkg::ST_DRAIN;
        end
      end
      cnzr_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = cnzr_pkg::ST_EMIT;
        end
      end
      cnzr_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = cnzr_pkg::ST_RUN;
        end
      end
      default: state_nxt = cnzr_pkg::ST_RUN;
    endcase
  end

  // The sweep reads and zeroes bins below the bin count; the rest are only zeroed.
  always_comb begin
    ready_o   = (state_r == cnzr_pkg::ST_RUN);
    issue_ok  = !rd_pend_r && (!out_valid_r || out_tready_i);
    in_range  = BIN_W'(ptr_r) < nb_r;
    emit_act  = (state_r == cnzr_pkg::ST_EMIT) && (!in_range || issue_ok);
    emit_read = (state_r == cnzr_pkg::ST_EMIT) && in_range && issue_ok;
    emit_done = emit_act && (ptr_r == AW'(OUT_BINS - 1));
    if (state_r == cnzr_pkg::ST_EMIT) begin
      mem_we    = emit_act;
      mem_waddr = ptr_r;
      mem_wdata = '0;
      mem_re    = emit_read;
      mem_raddr = ptr_r;
    end else begin
      mem_we    = wb_r.valid && wb_r.inc;
      mem_waddr = wb_r.bin[AW-1:0];
      mem_wdata = wb_new;
      mem_re    = item_i.valid && item_i.inc;
      mem_raddr = item_i.bin[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnzr_pkg::ST_EMIT;
      ptr_r       <= '0;
      nb_r        <= '0;
      wb_r        <= '0;
      fwd_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_r        <= item_i;
      fwd_valid_r <= mem_we;
      rd_pend_r   <= emit_read;
      if (emit_act) begin
        ptr_r <= emit_done ? '0 : ptr_r + 1'b1;
      end
      if (state_r == cnzr_pkg::ST_DRAIN && drain_done) begin
        nb_r <= wb_r.nbins;
      end
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= mem_waddr;
    fwd_data_r <= mem_wdata;
    rd_bin_r   <= ptr_r;
    rd_last_r  <= (BIN_W'(ptr_r) + BIN_W'(1)) == nb_r;
    if (rd_pend_r) begin
      out_bin_r   <= cnzr_pkg::BIN_OUT_W'(rd_bin_r);
      out_count_r <= rdata_r;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_bin_o   = out_bin_r;
  assign out_count_o = out_count_r;
  assign out_last_o  = out_last_r;

`ifndef SYNTHESIS
  a_emit_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cnzr_pkg::ST_EMIT |-> !wb_r.valid)
    else $error("element in counter update stage during bin sweep");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("bin read returned while output register still full");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |-> state_r == cnzr_pkg::ST_DRAIN)
    else $error("final element reached counters outside drain");

  a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && out_tready_i |=> !out_valid_r || !out_last_r || rd_pend_r
      || $past(rd_pend_r))
    else $error("last bin word repeated");
`endif

endmodule
